// ----- src/hsl_pkg.sv -----
// Shared types and constants for the HTTP status line parser.
// No dependencies; imported by every module of the block.
`default_nettype none
package hsl_pkg;

  localparam int CODE_BITS = 10;
  localparam int SHOW_BITS = 10;
  localparam int ADDR_BITS = 3;

  localparam logic [SHOW_BITS-1:0] MIN_CODE_RST = SHOW_BITS'(100);
  localparam logic [SHOW_BITS-1:0] MAX_CODE_RST = SHOW_BITS'(599);

  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic REG_MIN_CODE = 1'b0;
  localparam logic REG_MAX_CODE = 1'b1;

  typedef enum logic [2:0] {
    KIND_PROTO   = 3'd0,
    KIND_DIGIT   = 3'd1,
    KIND_SEP     = 3'd2,
    KIND_REASON  = 3'd3,
    KIND_DONE    = 3'd4,
    KIND_ERROR   = 3'd5,
    KIND_IGNORED = 3'd6
  } byte_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_CODE     = 3'd1,
    ERR_NONDIGIT = 3'd2,
    ERR_CONTROL  = 3'd3,
    ERR_NOLF     = 3'd4
  } error_kind_e;

  typedef struct packed {
    logic [SHOW_BITS-1:0] min_code;
    logic [SHOW_BITS-1:0] max_code;
  } hsl_cfg_t;

endpackage
`default_nettype wire

// ----- src/hsl_cfg_regs.sv -----
// APB register file holding the accepted status code range.
// Depends on hsl_pkg.
`default_nettype none
module hsl_cfg_regs
  import hsl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output hsl_cfg_t                  cfg_o
);

  logic [SHOW_BITS-1:0] min_code_q;
  logic [SHOW_BITS-1:0] max_code_q;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_code_q <= MIN_CODE_RST;
      max_code_q <= MAX_CODE_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MIN_CODE: min_code_q <= pwdata[SHOW_BITS-1:0];
        REG_MAX_CODE: max_code_q <= pwdata[SHOW_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_CODE: prdata = 32'(min_code_q);
      REG_MAX_CODE: prdata = 32'(max_code_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.min_code = min_code_q;
  assign cfg_o.max_code = max_code_q;

endmodule
`default_nettype wire

// ----- src/hsl_core.sv -----
// Parse state and result register: one byte classified per accepted item.
// Depends on hsl_pkg.
`default_nettype none
module hsl_core
  import hsl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hsl_cfg_t             cfg_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           byte_value_i,
  input  wire logic                 restart_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [2:0]           byte_kind_o,
  output logic      [7:0]           byte_echo_o,
  output logic      [SHOW_BITS-1:0] status_code_o,
  output logic      [2:0]           error_kind_o
);

  typedef enum logic [2:0] {
    PH_PROTO  = 3'd0,
    PH_CODE   = 3'd1,
    PH_REASON = 3'd2,
    PH_LF     = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_e;

  localparam int WIDE_BITS = CODE_BITS + 4;

  phase_e               phase_q, phase_d, phase_c;
  logic [CODE_BITS-1:0] code_q, code_d, code_c;
  logic [2:0]           cnt_q, cnt_d, cnt_c;
  error_kind_e          err_q, err_d, err_c;
  logic                 out_valid_q;
  byte_kind_e           kind_q, kind_d;
  logic [7:0]           echo_q;
  logic [SHOW_BITS-1:0] show_q, show_d;
  logic                 accept;
  logic [WIDE_BITS-1:0] code_next;
  logic [15:0]          code_wide;
  logic [15:0]          min_wide;
  logic [15:0]          max_wide;
  logic                 code_good;
  logic                 is_digit;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    phase_c = phase_q;
    code_c  = code_q;
    cnt_c   = cnt_q;
    err_c   = err_q;
    if (restart_i) begin
      phase_c = PH_PROTO;
      code_c  = '0;
      cnt_c   = '0;
      err_c   = ERR_NONE;
    end
  end

  assign is_digit  = (byte_value_i >= CH_ZERO) && (byte_value_i <= CH_NINE);
  assign code_next = (WIDE_BITS'(code_c) << 3) + (WIDE_BITS'(code_c) << 1)
                   + WIDE_BITS'(byte_value_i[3:0]);
  assign code_wide = 16'(code_c);
  assign min_wide  = 16'(cfg_i.min_code);
  assign max_wide  = 16'(cfg_i.max_code);
  assign code_good = (cnt_c != 3'd0) && (code_wide >= min_wide) && (code_wide <= max_wide);

  always_comb begin
    phase_d = phase_c;
    code_d  = code_c;
    cnt_d   = cnt_c;
    err_d   = err_c;
    kind_d  = KIND_IGNORED;
    case (phase_c)
      PH_PROTO: begin
        if (byte_value_i == CH_SP) begin
          phase_d = PH_CODE;
          kind_d  = KIND_SEP;
        end else begin
          kind_d = KIND_PROTO;
        end
      end
      PH_CODE: begin
        if (byte_value_i == CH_SP || byte_value_i == CH_CR) begin
          if (code_good) begin
            phase_d = (byte_value_i == CH_SP) ? PH_REASON : PH_LF;
            kind_d  = KIND_SEP;
          end else begin
            phase_d = PH_ERROR;
            err_d   = ERR_CODE;
            kind_d  = KIND_ERROR;
          end
        end else if (is_digit) begin
          if (code_next[WIDE_BITS-1:CODE_BITS] != '0) begin
            code_d = '1;
          end else begin
            code_d = code_next[CODE_BITS-1:0];
          end
          if (cnt_c != 3'd7) begin
            cnt_d = cnt_c + 3'd1;
          end
          kind_d = KIND_DIGIT;
        end else begin
          phase_d = PH_ERROR;
          err_d   = ERR_NONDIGIT;
          kind_d  = KIND_ERROR;
        end
      end
      PH_REASON: begin
        if (byte_value_i == CH_CR) begin
          phase_d = PH_LF;
          kind_d  = KIND_SEP;
        end else if (byte_value_i != CH_HT &&
                     (byte_value_i < CH_SP || byte_value_i == CH_DEL)) begin
          phase_d = PH_ERROR;
          err_d   = ERR_CONTROL;
          kind_d  = KIND_ERROR;
        end else begin
          kind_d = KIND_REASON;
        end
      end
      PH_LF: begin
        if (byte_value_i == CH_LF) begin
          phase_d = PH_DONE;
          kind_d  = KIND_DONE;
        end else begin
          phase_d = PH_ERROR;
          err_d   = ERR_NOLF;
          kind_d  = KIND_ERROR;
        end
      end
      PH_DONE: kind_d = KIND_IGNORED;
      default: kind_d = KIND_ERROR;
    endcase
  end

  always_comb begin
    if (16'(code_d) > 16'((1 << SHOW_BITS) - 1)) begin
      show_d = '1;
    end else begin
      show_d = SHOW_BITS'(code_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PROTO;
      code_q      <= '0;
      cnt_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | (out_valid_q & out_stall_i);
      if (accept) begin
        phase_q <= phase_d;
        code_q  <= code_d;
        cnt_q   <= cnt_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_d;
      echo_q <= byte_value_i;
      show_q <= show_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_kind_o   = kind_q;
  assign byte_echo_o   = echo_q;
  assign status_code_o = show_q;
  assign error_kind_o  = err_q;

endmodule
`default_nettype wire

// ----- src/http_status_line_parser.sv -----
// Each accepted byte's result item appears on the outputs in the cycle after it.
// Throughput: one byte per cycle; the input stalls only while a result is held
// by a stalled output. Range check is combinational; parse state is registered.
// Reset: asynchronous, active low; returns the parser to the protocol field and
// sets the code range to 100..599. Top level; depends on hsl_pkg,
// hsl_cfg_regs and hsl_core.
`default_nettype none
module http_status_line_parser
  import hsl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           byte_value_i,
  input  wire logic                 restart_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [2:0]           byte_kind_o,
  output logic      [7:0]           byte_echo_o,
  output logic      [SHOW_BITS-1:0] status_code_o,
  output logic      [2:0]           error_kind_o
);

  hsl_cfg_t cfg;

  hsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hsl_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_kind_o   (byte_kind_o),
    .byte_echo_o   (byte_echo_o),
    .status_code_o (status_code_o),
    .error_kind_o  (error_kind_o)
  );

endmodule
`default_nettype wire
